// ===== design/psf_pkg.sv =====
// Shared types and constants of the power series sum fraction core.
// Used by psf_div and power_series_sum_fraction_core; depends on nothing.
package psf_pkg;

  localparam int VAL_W  = 63;   // width of every checked intermediate value
  localparam int MUL_W  = 16;   // width of the small factor of the multiply-add
  localparam int ORD_W  = 5;    // width of the order field and its counters
  localparam int BASE_W = 16;   // width of the base field
  localparam int ST_W   = 2;
  localparam int SH_W   = 6;    // common power of two count in the gcd

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_DIVERGENT = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

endpackage

// ===== design/psf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the reduced fraction.
// Depends on psf_pkg for the value width and the request struct.
module psf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  psf_pkg::div_req_t req,
  output logic              done,
  output psf_pkg::val_t     quotient
);

  logic                     busy_r;
  logic                     done_r;
  logic [psf_pkg::SH_W-1:0] cnt_r;
  psf_pkg::val_t            rem_r;
  psf_pkg::val_t            q_r;
  psf_pkg::val_t            dvsr_r;
  logic [psf_pkg::VAL_W:0]  rem_sh;
  logic [psf_pkg::VAL_W:0]  rem_sub;
  logic                     ge;

  assign rem_sh  = {rem_r, q_r[psf_pkg::VAL_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_r};
  assign ge      = rem_sh >= {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == psf_pkg::SH_W'(psf_pkg::VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      q_r    <= req.dividend;
      dvsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[psf_pkg::VAL_W-1:0] : rem_sh[psf_pkg::VAL_W-1:0];
      q_r   <= {q_r[psf_pkg::VAL_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== design/power_series_sum_fraction_core.sv =====
// Power series sum fraction core: sum over n>=1 of n^a / b^n as a reduced fraction.
// Steps for order a: the Eulerian row, the numerator and denominator, the binary gcd
// and two divisions by the gcd.
// One transaction in flight; the rate is set by the shared multiply-add and divider.
// Base zero, base one or order above MAX_ORDER skip the computation and go straight to the result.
// Reset (rst_n, synchronous) returns the sequencer to idle and drops any result.
module power_series_sum_fraction_core #(
  parameter int MAX_ORDER = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [psf_pkg::ORD_W-1:0]   in_order,
  input  logic [psf_pkg::BASE_W-1:0]  in_base,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [psf_pkg::VAL_W-1:0]   out_numerator,
  output logic [psf_pkg::VAL_W-1:0]   out_denominator,
  output logic [psf_pkg::ST_W-1:0]    out_status
);

  localparam int ROW_D = MAX_ORDER + 1;
  localparam int IDX_W = (ROW_D > 1) ? $clog2(ROW_D) : 1;
  localparam int PRD_W = psf_pkg::VAL_W + psf_pkg::MUL_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_HR   = 4'd5;
  localparam logic [3:0] S_HM   = 4'd6;
  localparam logic [3:0] S_DEN  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_GCD  = 4'd9;
  localparam logic [3:0] S_DVS1 = 4'd10;
  localparam logic [3:0] S_DVW1 = 4'd11;
  localparam logic [3:0] S_DVS2 = 4'd12;
  localparam logic [3:0] S_DVW2 = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]                   state_r;
  logic [psf_pkg::ORD_W-1:0]    a_r;
  logic [psf_pkg::BASE_W-1:0]   b_r;
  logic [psf_pkg::ORD_W-1:0]    n_r;
  logic [psf_pkg::ORD_W-1:0]    k_r;
  logic [psf_pkg::ORD_W-1:0]    wc_r;     // rows of the Eulerian table written so far
  logic                         ovf_r;
  psf_pkg::val_t                tmp_r;
  psf_pkg::val_t                num_r;
  psf_pkg::val_t                den_r;
  psf_pkg::val_t                u_r;
  psf_pkg::val_t                v_r;
  psf_pkg::val_t                g_r;
  logic [psf_pkg::SH_W-1:0]     sh_r;
  psf_pkg::val_t                res_num_r;
  psf_pkg::val_t                res_den_r;
  logic [psf_pkg::ST_W-1:0]     res_st_r;
  logic                         out_valid_r;
  psf_pkg::val_t                out_num_r;
  psf_pkg::val_t                out_den_r;
  logic [psf_pkg::ST_W-1:0]     out_st_r;

  psf_pkg::val_t                row_mem [ROW_D];
  psf_pkg::val_t                rd_q_r;

  logic [psf_pkg::ORD_W-1:0]    km1;
  logic [IDX_W-1:0]             rd_addr;
  logic [psf_pkg::ORD_W-1:0]    rv_idx;
  psf_pkg::val_t                row_val;
  psf_pkg::val_t                mul_a;
  logic [psf_pkg::MUL_W-1:0]    mul_m;
  psf_pkg::val_t                mul_add;
  logic [PRD_W-1:0]             mul_prod;
  logic [PRD_W:0]               mul_res;
  logic                         mul_ovf;
  logic                         in_acc;
  logic                         out_free;
  psf_pkg::div_req_t            div_req;
  logic                         div_done;
  psf_pkg::val_t                div_q;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Row table: one read port with registered data, one write port.
  assign km1     = k_r - 1'b1;
  assign rd_addr = (state_r == S_RD2 && k_r != '0) ? km1[IDX_W-1:0] : k_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    rd_q_r <= row_mem[rd_addr];
    if (state_r == S_M2) begin
      row_mem[k_r[IDX_W-1:0]] <= mul_res[psf_pkg::VAL_W-1:0];
    end
  end

  // Entries not yet written read as the seed row: one at index zero, else zero.
  assign rv_idx = (state_r == S_M2) ? km1 : k_r;
  always_comb begin
    if (state_r == S_M2 && k_r == '0) begin
      row_val = '0;
    end else if (rv_idx < wc_r) begin
      row_val = rd_q_r;
    end else if (rv_idx == '0) begin
      row_val = psf_pkg::VAL_W'(1);
    end else begin
      row_val = '0;
    end
  end

  // Shared multiply-add: value times small factor plus addend, checked for overflow.
  always_comb begin
    mul_a   = '0;
    mul_m   = '0;
    mul_add = '0;
    case (state_r)
      S_M1: begin
        mul_a = row_val;
        mul_m = psf_pkg::MUL_W'(k_r) + 1'b1;
      end
      S_M2: begin
        mul_a   = row_val;
        mul_m   = psf_pkg::MUL_W'(n_r - k_r);
        mul_add = tmp_r;
      end
      S_HM: begin
        mul_a   = num_r;
        mul_m   = b_r;
        mul_add = row_val;
      end
      S_DEN: begin
        mul_a = den_r;
        mul_m = b_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign mul_prod = PRD_W'(mul_a) * PRD_W'(mul_m);
  assign mul_res  = {1'b0, mul_prod} + (PRD_W + 1)'(mul_add);
  assign mul_ovf  = |mul_res[PRD_W:psf_pkg::VAL_W];

  // Divider requests for the two reductions by the gcd.
  always_comb begin
    div_req.start    = (state_r == S_DVS1) || (state_r == S_DVS2);
    div_req.dividend = (state_r == S_DVS2) ? den_r : num_r;
    div_req.divisor  = g_r;
  end

  psf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: Eulerian row, Horner numerator, denominator power, gcd, reduce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            a_r   <= in_order;
            b_r   <= in_base;
            ovf_r <= 1'b0;
            wc_r  <= '0;
            k_r   <= '0;
            n_r   <= psf_pkg::ORD_W'(1);
            num_r <= '0;
            if (in_base == psf_pkg::BASE_W'(1)) begin
              res_num_r <= '0;
              res_den_r <= '0;
              res_st_r  <= psf_pkg::ST_DIVERGENT;
              state_r   <= S_DONE;
            end else if (in_base == '0) begin
              res_num_r <= '0;
              res_den_r <= psf_pkg::VAL_W'(1);
              res_st_r  <= psf_pkg::ST_OK;
              state_r   <= S_DONE;
            end else if (in_order > psf_pkg::ORD_W'(MAX_ORDER)) begin
              res_num_r <= '0;
              res_den_r <= '0;
              res_st_r  <= psf_pkg::ST_OVERFLOW;
              state_r   <= S_DONE;
            end else if (in_order == '0) begin
              state_r <= S_HR;
            end else begin
              state_r <= S_RD1;
            end
          end
        end
        S_RD1: state_r <= S_M1;
        S_M1: begin
          tmp_r   <= mul_res[psf_pkg::VAL_W-1:0];
          ovf_r   <= ovf_r | mul_ovf;
          state_r <= S_RD2;
        end
        S_RD2: state_r <= S_M2;
        S_M2: begin
          // descending k keeps row[k-1] from the previous row
          ovf_r <= ovf_r | mul_ovf;
          if (k_r == '0) begin
            wc_r <= n_r;
            if (n_r == a_r) begin
              k_r     <= '0;
              state_r <= S_HR;
            end else begin
              n_r     <= n_r + 1'b1;
              k_r     <= n_r;
              state_r <= S_RD1;
            end
          end else begin
            k_r     <= km1;
            state_r <= S_RD1;
          end
        end
        S_HR: state_r <= S_HM;
        S_HM: begin
          num_r <= mul_res[psf_pkg::VAL_W-1:0];
          ovf_r <= ovf_r | mul_ovf;
          if (k_r == a_r) begin
            k_r     <= '0;
            den_r   <= psf_pkg::VAL_W'(1);
            state_r <= S_DEN;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_HR;
          end
        end
        S_DEN: begin
          den_r <= mul_res[psf_pkg::VAL_W-1:0];
          ovf_r <= ovf_r | mul_ovf;
          if (k_r == a_r) begin
            state_r <= S_CHK;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_CHK: begin
          if (ovf_r) begin
            res_num_r <= '0;
            res_den_r <= '0;
            res_st_r  <= psf_pkg::ST_OVERFLOW;
            state_r   <= S_DONE;
          end else begin
            u_r     <= num_r;
            v_r     <= den_r;
            sh_r    <= '0;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          // binary gcd: one shift or one subtract per cycle
          if (u_r == '0) begin
            g_r     <= v_r << sh_r;
            state_r <= S_DVS1;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r  <= u_r >> 1;
            v_r  <= v_r >> 1;
            sh_r <= sh_r + 1'b1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
        S_DVS1: state_r <= S_DVW1;
        S_DVW1: begin
          if (div_done) begin
            res_num_r <= div_q;
            state_r   <= S_DVS2;
          end
        end
        S_DVS2: state_r <= S_DVW2;
        S_DVW2: begin
          if (div_done) begin
            res_den_r <= div_q;
            res_st_r  <= psf_pkg::ST_OK;
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register: hold the transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_num_r <= res_num_r;
      out_den_r <= res_den_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;
  assign out_status      = out_st_r;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for power_series_sum_fraction_core: predicts each reduced fraction.
// Depends on psf_pkg and the core; queue-fed driver and clocked monitor, random idling.
module tb;

  localparam int MAX_ORD = 16;
  localparam longint unsigned LIMIT63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [psf_pkg::ORD_W-1:0]  order;
    logic [psf_pkg::BASE_W-1:0] base;
  } series_item_t;

  typedef struct {
    psf_pkg::val_t             num;
    psf_pkg::val_t             den;
    logic [psf_pkg::ST_W-1:0]  st;
  } fraction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [psf_pkg::ORD_W-1:0] in_order = '0;
  logic [psf_pkg::BASE_W-1:0] in_base = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psf_pkg::val_t out_numerator, out_denominator;
  logic [psf_pkg::ST_W-1:0] out_status;

  series_item_t pending_items[$];
  fraction_t expected_fractions[$];
  bit stimulus_loaded = 1'b0;
  int errors = 0;
  int cycles = 0;
  int send_wait = 0;
  int recv_wait = 0;

  power_series_sum_fraction_core #(.MAX_ORDER(MAX_ORD)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_order(in_order), .in_base(in_base),
    .out_valid(out_valid), .out_stall(out_stall), .out_numerator(out_numerator),
    .out_denominator(out_denominator), .out_status(out_status)
  );

  always #5 clk = ~clk;

  // Saturating helpers: flag overflow past 2^63-1 instead of wrapping
  function automatic longint unsigned mul_sat(longint unsigned x, longint unsigned y,
                                              ref bit ovf);
    if (x != 0 && y > LIMIT63 / x) begin
      ovf = 1'b1;
      return 0;
    end
    return x * y;
  endfunction

  function automatic longint unsigned add_sat(longint unsigned x, longint unsigned y,
                                              ref bit ovf);
    if (x > LIMIT63 || y > LIMIT63 - x) begin
      ovf = 1'b1;
      return 0;
    end
    return x + y;
  endfunction

  function automatic longint unsigned pow_sat(longint unsigned x, int e, ref bit ovf);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < e; i++) r = mul_sat(r, x, ovf);
    return r;
  endfunction

  // Eulerian row, weighted numerator, denominator (b-1)^(a+1), then reduce by gcd
  function automatic fraction_t series_fraction(series_item_t it);
    longint unsigned row[MAX_ORD+1];
    longint unsigned num, den, g, x, y, t, t1, t2;
    bit ovf;
    int a;
    fraction_t f;
    a = int'(it.order);
    ovf = 1'b0;
    num = 0;
    f.num = '0;
    f.den = '0;
    f.st = psf_pkg::ST_OVERFLOW;
    if (it.base == 1) begin
      f.st = psf_pkg::ST_DIVERGENT;
      return f;
    end
    if (it.base == 0) begin
      f.den = psf_pkg::VAL_W'(1);
      f.st = psf_pkg::ST_OK;
      return f;
    end
    if (a > MAX_ORD) return f;
    foreach (row[i]) row[i] = 0;
    row[0] = 1;
    for (int n = 1; n <= a; n++) begin
      for (int k = n - 1; k >= 0; k--) begin
        t2 = mul_sat(k + 1, row[k], ovf);
        t1 = 0;
        if (k > 0) t1 = mul_sat(n - k, row[k-1], ovf);
        row[k] = add_sat(t1, t2, ovf);
      end
    end
    for (int k = 0; k <= a; k++) begin
      if (row[k] != 0)
        num = add_sat(num, mul_sat(row[k], pow_sat(it.base, a - k, ovf), ovf), ovf);
    end
    den = pow_sat(it.base - 1, a + 1, ovf);
    if (ovf || den == 0 || num == 0) return f;
    x = num;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = x;
    f.num = psf_pkg::VAL_W'(num / g);
    f.den = psf_pkg::VAL_W'(den / g);
    f.st = psf_pkg::ST_OK;
    return f;
  endfunction

  function automatic series_item_t mk(int o, int b);
    series_item_t it;
    it.order = psf_pkg::ORD_W'(o);
    it.base = psf_pkg::BASE_W'(b);
    return it;
  endfunction

  // Fill the queue: directed corners first, then mostly in-range random items
  initial begin
    int r;
    pending_items.push_back(mk(0, 0));
    pending_items.push_back(mk(31, 0));
    pending_items.push_back(mk(0, 1));
    pending_items.push_back(mk(31, 1));
    pending_items.push_back(mk(0, 2));
    pending_items.push_back(mk(0, 3));
    pending_items.push_back(mk(1, 2));
    pending_items.push_back(mk(2, 2));
    pending_items.push_back(mk(16, 2));
    pending_items.push_back(mk(16, 3));
    pending_items.push_back(mk(17, 2));
    pending_items.push_back(mk(31, 65535));
    pending_items.push_back(mk(0, 65535));
    pending_items.push_back(mk(1, 65535));
    pending_items.push_back(mk(4, 65535));
    pending_items.push_back(mk(3, 10));
    pending_items.push_back(mk(5, 7));
    pending_items.push_back(mk(16, 65535));
    pending_items.push_back(mk(8, 256));
    pending_items.push_back(mk(21, 21));
    for (int i = 0; i < 1250; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6)
        pending_items.push_back(mk($urandom_range(0, 16), $urandom_range(2, 40)));
      else if (r < 8)
        pending_items.push_back(mk($urandom_range(0, 16), $urandom_range(0, 65535)));
      else if (r < 9)
        pending_items.push_back(mk($urandom_range(0, 31), $urandom_range(0, 3)));
      else
        pending_items.push_back(mk($urandom_range(0, 31), $urandom_range(0, 65535)));
    end
    stimulus_loaded = 1'b1;
  end

  // Driver: hold the transaction while stalled, advance after acceptance and a gap
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 7) rst_n <= 1'b1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_fractions.push_back(series_fraction(mk(in_order, in_base)));
        void'(pending_items.pop_front());
        send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (stimulus_loaded && pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_order <= pending_items[0].order;
        in_base <= pending_items[0].base;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    fraction_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_fractions.size() == 0) begin
          $error("result with no expectation pending");
          errors++;
        end else begin
          e = expected_fractions.pop_front();
          if (out_numerator !== e.num) begin
            $error("numerator expected %0d actual %0d", e.num, out_numerator);
            errors++;
          end
          if (out_denominator !== e.den) begin
            $error("denominator expected %0d actual %0d", e.den, out_denominator);
            errors++;
          end
          if (out_status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, out_status);
            errors++;
          end
        end
        recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End of run: drain, let the latency pass, then report
  initial begin
    wait (stimulus_loaded && rst_n);
    wait ((pending_items.size() == 0 && expected_fractions.size() == 0 && !in_valid)
          || cycles >= CYCLE_LIMIT);
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
    end else begin
      repeat (500) @(posedge clk);
      if (errors == 0 && expected_fractions.size() == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/psf_pkg.sv
design/psf_div.sv
design/power_series_sum_fraction_core.sv
test/tb.sv
